>>> rtl/mbld_pkg.sv
// Shared types and constants for the multi-button lockout debouncer.
// Used by the lane, merge and top-level modules; depends on nothing.
package mbld_pkg;

    localparam int DT_W    = 16;
    localparam int RAW_W   = 8;
    localparam int FLAG_W  = 8;
    localparam int DEB_W   = 16;
    localparam int COUNT_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW    = 2'd2;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET   = 16'd100;
    localparam logic [COUNT_W-1:0] COUNT_RESET      = 4'd8;
    localparam logic               ACTIVE_LOW_RESET = 1'b1;

    // Per-lane findings for one tick.
    typedef struct packed {
        logic held;
        logic pressed;
        logic released;
        logic clicked;
    } lane_flags_t;

    // One result beat.
    typedef struct packed {
        logic [FLAG_W-1:0] held_flags;
        logic [FLAG_W-1:0] pressed_flags;
        logic [FLAG_W-1:0] released_flags;
        logic [FLAG_W-1:0] clicked_flags;
    } result_t;

endpackage

>>> rtl/multi_button_lockout_debouncer_core.sv
// An accepted tick's result beat is registered in the output register, or in the skid register if that is full.
// Throughput: one tick per cycle; every lane updates in parallel on the same edge.
// The input side stalls only when both the output and skid registers are full.
// Reset (aresetn, synchronous, active low): all timers, held and armed bits clear,
// both result registers empty, registers return to debounce 100, 8 buttons, active low.
module multi_button_lockout_debouncer_core #(
    parameter int NUM_BUTTONS = 8,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mbld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mbld_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [mbld_pkg::DT_W-1:0]       s_dt_ms,
    input  logic [mbld_pkg::RAW_W-1:0]      s_raw_levels,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mbld_pkg::FLAG_W-1:0]     m_held_flags,
    output logic [mbld_pkg::FLAG_W-1:0]     m_pressed_flags,
    output logic [mbld_pkg::FLAG_W-1:0]     m_released_flags,
    output logic [mbld_pkg::FLAG_W-1:0]     m_clicked_flags
);

    // Configuration registers. The user must write them only while the block is idle; the block does not
    // enforce this, and writes are taken directly with no interlock against the lanes.
    logic [mbld_pkg::DEB_W-1:0]   debounce_time_reg;
    logic [mbld_pkg::COUNT_W-1:0] button_count_reg;
    logic                         active_low_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg <= mbld_pkg::DEBOUNCE_RESET;
            button_count_reg  <= mbld_pkg::COUNT_RESET;
            active_low_reg    <= mbld_pkg::ACTIVE_LOW_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mbld_pkg::CFG_DEBOUNCE_TIME: begin
                    debounce_time_reg <= cfg_wdata[mbld_pkg::DEB_W-1:0];
                end
                mbld_pkg::CFG_BUTTON_COUNT: begin
                    button_count_reg <= cfg_wdata[mbld_pkg::COUNT_W-1:0];
                end
                mbld_pkg::CFG_ACTIVE_LOW: begin
                    active_low_reg <= cfg_wdata[0];
                end
                default: begin
                end
            endcase
        end
    end

    // A tick beat is taken whenever one is offered and the merge stage has room; the lanes
    // advance their state on exactly that edge.
    logic                  accept;
    logic                  merge_ready;
    mbld_pkg::lane_flags_t lane_flags [NUM_BUTTONS];
    mbld_pkg::result_t     out_beat;

    assign s_ready = merge_ready;
    assign accept  = s_valid && merge_ready;

    // One lane per button. Lanes without a raw input bit see a constant raw
    // level of zero, exactly as the eight-bit raw field implies.
    genvar li;
    generate
        for (li = 0; li < NUM_BUTTONS; li++) begin : g_lane
            logic raw_bit;
            if (li < mbld_pkg::RAW_W) begin : g_raw
                assign raw_bit = s_raw_levels[li];
            end else begin : g_zero
                assign raw_bit = 1'b0;
            end

            mbld_lane #(
                .LANE_IDX    (li),
                .TIMER_WIDTH (TIMER_WIDTH)
            ) u_lane (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .step          (accept),
                .dt_ms         (s_dt_ms),
                .raw_level     (raw_bit),
                .debounce_time (debounce_time_reg),
                .button_count  (button_count_reg),
                .active_low    (active_low_reg),
                .flags         (lane_flags[li])
            );
        end
    endgenerate

    // Gathers the lane findings into one result beat and buffers it.
    mbld_merge #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .lane_flags (lane_flags),
        .in_ready   (merge_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_beat   (out_beat)
    );

    assign m_held_flags     = out_beat.held_flags;
    assign m_pressed_flags  = out_beat.pressed_flags;
    assign m_released_flags = out_beat.released_flags;
    assign m_clicked_flags  = out_beat.clicked_flags;

endmodule

>>> rtl/mbld_lane.sv
// One button lane: lockout timer, held state and click arming.
// Depends on mbld_pkg for the lane flag type and field widths.
module mbld_lane #(
    parameter int LANE_IDX    = 0,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,
    input  logic [mbld_pkg::DT_W-1:0]    dt_ms,
    input  logic                         raw_level,
    input  logic [mbld_pkg::DEB_W-1:0]   debounce_time,
    input  logic [mbld_pkg::COUNT_W-1:0] button_count,
    input  logic                         active_low,
    output mbld_pkg::lane_flags_t        flags
);

    localparam int CW = (TIMER_WIDTH > mbld_pkg::DT_W) ? TIMER_WIDTH : mbld_pkg::DT_W;

    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic                   held_reg, held_next;
    logic                   armed_reg, armed_next;

    logic          active;
    logic [CW-1:0] timer_ext, dt_ext, deb_ext, diff;
    logic          reading;

    assign active    = (32'(button_count) > LANE_IDX);
    assign timer_ext = CW'(timer_reg);
    assign dt_ext    = CW'(dt_ms);
    assign deb_ext   = CW'(debounce_time);
    assign diff      = timer_ext - dt_ext;
    assign reading   = raw_level ^ active_low;

    always_comb begin
        timer_next = timer_reg;
        held_next  = held_reg;
        armed_next = armed_reg;
        flags      = '0;
        if (!active) begin
            timer_next = '0;
            held_next  = 1'b0;
            armed_next = 1'b0;
        end else if (timer_ext >= dt_ext) begin
            timer_next = diff[TIMER_WIDTH-1:0];
        end else begin
            timer_next = '0;
            if (reading != held_reg) begin
                timer_next = deb_ext[TIMER_WIDTH-1:0];
                held_next  = reading;
                if (reading) begin
                    flags.pressed = 1'b1;
                    armed_next    = 1'b1;
                end else begin
                    flags.released = 1'b1;
                    if (armed_reg) begin
                        flags.clicked = 1'b1;
                        armed_next    = 1'b0;
                    end
                end
            end
        end
        flags.held = held_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg <= '0;
            held_reg  <= 1'b0;
            armed_reg <= 1'b0;
        end else if (step) begin
            timer_reg <= timer_next;
            held_reg  <= held_next;
            armed_reg <= armed_next;
        end
    end

endmodule

>>> rtl/mbld_merge.sv
// Merge stage: packs lane findings into a result beat and holds it in an
// output register backed by a skid register. Depends on mbld_pkg.
module mbld_merge #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  load,
    input  mbld_pkg::lane_flags_t lane_flags [NUM_BUTTONS],
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mbld_pkg::result_t     out_beat
);

    mbld_pkg::result_t merged;
    mbld_pkg::result_t out_reg, skid_reg;
    logic              out_valid_reg, skid_valid_reg;
    logic              pop;

    genvar gi;
    generate
        for (gi = 0; gi < mbld_pkg::FLAG_W; gi++) begin : g_bit
            if (gi < NUM_BUTTONS) begin : g_lane
                assign merged.held_flags[gi]     = lane_flags[gi].held;
                assign merged.pressed_flags[gi]  = lane_flags[gi].pressed;
                assign merged.released_flags[gi] = lane_flags[gi].released;
                assign merged.clicked_flags[gi]  = lane_flags[gi].clicked;
            end else begin : g_none
                assign merged.held_flags[gi]     = 1'b0;
                assign merged.pressed_flags[gi]  = 1'b0;
                assign merged.released_flags[gi] = 1'b0;
                assign merged.clicked_flags[gi]  = 1'b0;
            end
        end
    endgenerate

    assign pop       = out_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (load) begin
            if (!out_valid_reg || pop) begin
                out_reg       <= merged;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= merged;
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

endmodule
